@@ hw/rtl/kspc_pkg.sv @@
// Package for the key short/long press classifier.
// Holds field widths, register indexes and reset values, phase and action codes and the shared structs.
// No dependencies.
package kspc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned PORT_W  = 8;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SHORT_MIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_LONG_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_COOLDOWN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESUME    = 3'd4;
    localparam logic [IDX_W-1:0] REG_KEY_MASK  = 3'd5;

    // register reset values
    localparam logic [CFG_W-1:0]  RST_DEBOUNCE  = 16'd25;
    localparam logic [CFG_W-1:0]  RST_SHORT_MIN = 16'd30;
    localparam logic [CFG_W-1:0]  RST_LONG_MIN  = 16'd450;
    localparam logic [CFG_W-1:0]  RST_COOLDOWN  = 16'd180;
    localparam logic [CFG_W-1:0]  RST_RESUME    = 16'd150;
    localparam logic [PORT_W-1:0] RST_KEY_MASK  = 8'd4;

    // phase codes
    localparam logic [1:0] PH_REST  = 2'd0;
    localparam logic [1:0] PH_PEND  = 2'd1;
    localparam logic [1:0] PH_PRESS = 2'd2;

    // item kind
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // fired action codes
    localparam logic [1:0] FIRE_NONE      = 2'd0;
    localparam logic [1:0] FIRE_BACKLIGHT = 2'd1;
    localparam logic [1:0] FIRE_WAKE      = 2'd2;
    localparam logic [1:0] FIRE_TOUCH     = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0]  debounce_time;
        logic [CFG_W-1:0]  short_hold_min;
        logic [CFG_W-1:0]  long_hold_min;
        logic [CFG_W-1:0]  cooldown_ms;
        logic [CFG_W-1:0]  resume_block_ms;
        logic [PORT_W-1:0] key_mask;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic [PORT_W-1:0] port_value;
        logic              read_ok;
        logic              boot_button_low;
        logic              sleep_active;
        logic [TIME_W-1:0] resume_time_ms;
        logic              touch_forced_off;
    } t_item;

    typedef struct packed {
        logic [1:0] fired_action;
        logic [1:0] machine_state;
        logic       sampling_on;
    } t_result;

endpackage

@@ hw/rtl/kspc_cfg.sv @@
// Configuration register file of the press classifier.
// Depends on kspc_pkg for register indexes, reset values and t_cfg.
module kspc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [kspc_pkg::IDX_W-1:0]   i_index,
    input  logic [kspc_pkg::CFG_W-1:0]   i_data,
    output kspc_pkg::t_cfg               o_cfg
);

    kspc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time      <= kspc_pkg::RST_DEBOUNCE;
            r_cfg.short_hold_min     <= kspc_pkg::RST_SHORT_MIN;
            r_cfg.long_hold_min      <= kspc_pkg::RST_LONG_MIN;
            r_cfg.cooldown_ms        <= kspc_pkg::RST_COOLDOWN;
            r_cfg.resume_block_ms    <= kspc_pkg::RST_RESUME;
            r_cfg.key_mask           <= kspc_pkg::RST_KEY_MASK;
        end else if (i_we) begin
            case (i_index)
                kspc_pkg::REG_DEBOUNCE:  r_cfg.debounce_time      <= i_data;
                kspc_pkg::REG_SHORT_MIN: r_cfg.short_hold_min     <= i_data;
                kspc_pkg::REG_LONG_MIN:  r_cfg.long_hold_min      <= i_data;
                kspc_pkg::REG_COOLDOWN:  r_cfg.cooldown_ms        <= i_data;
                kspc_pkg::REG_RESUME:    r_cfg.resume_block_ms    <= i_data;
                kspc_pkg::REG_KEY_MASK:  r_cfg.key_mask           <= i_data[kspc_pkg::PORT_W-1:0];
                default: ; // unknown index: dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/kspc_core.sv @@
// Press classifier state machine: phase, stored times and long-fired flag.
// Depends on kspc_pkg for codes, t_cfg, t_item and t_result.
module kspc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  kspc_pkg::t_cfg   i_cfg,
    input  kspc_pkg::t_item  i_item,
    output kspc_pkg::t_result o_result
);

    logic [1:0]                    r_phase, n_phase;
    logic [kspc_pkg::TIME_W-1:0]   r_edge_time, n_edge_time;
    logic [kspc_pkg::TIME_W-1:0]   r_press_start, n_press_start;
    logic [kspc_pkg::TIME_W-1:0]   r_last_fire, n_last_fire;
    logic                          r_long_done, n_long_done;

    logic [kspc_pkg::TIME_W-1:0]   since_resume, since_edge, since_fire, held;
    logic                          blocked, pressed, cool;
    logic [1:0]                    fired;

    always_comb begin
        since_resume = i_item.now_ms - i_item.resume_time_ms;
        since_edge   = i_item.now_ms - r_edge_time;
        since_fire   = i_item.now_ms - r_last_fire;
        held         = i_item.now_ms - r_press_start;
        blocked = (i_item.resume_time_ms != '0) &&
                  (since_resume < {16'd0, i_cfg.resume_block_ms});
        pressed = i_item.read_ok && ((i_item.port_value & i_cfg.key_mask) == '0);
        cool    = since_fire >= {16'd0, i_cfg.cooldown_ms};

        n_phase       = r_phase;
        n_edge_time   = r_edge_time;
        n_press_start = r_press_start;
        n_last_fire   = r_last_fire;
        n_long_done   = r_long_done;
        fired         = kspc_pkg::FIRE_NONE;

        if (i_item.action == kspc_pkg::ACT_EDGE) begin
            if (!i_item.sleep_active && !blocked && r_phase == kspc_pkg::PH_REST) begin
                n_phase     = kspc_pkg::PH_PEND;
                n_edge_time = i_item.now_ms;
            end
        end else if (blocked || i_item.sleep_active || i_item.boot_button_low) begin
            n_phase     = kspc_pkg::PH_REST;
            n_long_done = 1'b0;
        end else begin
            case (r_phase)
                kspc_pkg::PH_REST: ;
                kspc_pkg::PH_PEND: begin
                    if (since_edge >= {16'd0, i_cfg.debounce_time}) begin
                        if (pressed) begin
                            n_phase       = kspc_pkg::PH_PRESS;
                            n_press_start = i_item.now_ms;
                        end else begin
                            n_phase     = kspc_pkg::PH_REST;
                            n_long_done = 1'b0;
                        end
                    end
                end
                kspc_pkg::PH_PRESS: begin
                    if (pressed) begin
                        if (!r_long_done && cool &&
                            held >= {16'd0, i_cfg.long_hold_min}) begin
                            fired       = kspc_pkg::FIRE_BACKLIGHT;
                            n_long_done = 1'b1;
                            n_last_fire = i_item.now_ms;
                        end
                    end else begin
                        if (!r_long_done && cool &&
                            held >= {16'd0, i_cfg.short_hold_min}) begin
                            fired       = i_item.touch_forced_off ? kspc_pkg::FIRE_WAKE
                                                                  : kspc_pkg::FIRE_TOUCH;
                            n_last_fire = i_item.now_ms;
                        end
                        n_phase     = kspc_pkg::PH_REST;
                        n_long_done = 1'b0;
                    end
                end
                default: n_phase = kspc_pkg::PH_REST; // unused code falls back to rest
            endcase
        end

        o_result.fired_action  = fired;
        o_result.machine_state = n_phase;
        o_result.sampling_on   = (n_phase != kspc_pkg::PH_REST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= kspc_pkg::PH_REST;
            r_edge_time   <= '0;
            r_press_start <= '0;
            r_last_fire   <= '0;
            r_long_done   <= 1'b0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_edge_time   <= n_edge_time;
            r_press_start <= n_press_start;
            r_last_fire   <= n_last_fire;
            r_long_done   <= n_long_done;
        end
    end

endmodule

@@ hw/rtl/key_short_long_press_classifier_top.sv @@
// Top level of the key short/long press classifier.
// Depends on kspc_pkg, kspc_cfg and kspc_core.
//
// Usage:
//  - Slave stream: one transaction per interrupt edge or sample tick.
//    tuser carries the kind (0 edge, 1 tick); tdata carries time, port byte
//    and guard flags.
//  - Master stream: exactly one result transaction per input transaction,
//    in order: fired action, phase after the item, sampling request.
//  - Config channel: index/data writes, always ready; write only while idle.
//  - Path: an item passes the input register, then the result register;
//    state updates with the latter.
//  - Throughput: one item per cycle while the receiver takes every result, set
//    by the state loop in the core (compares against stored times, then the phase update).
//  - Reset (synchronous, active low): phase rest, stored times zero,
//    long-fired flag clear, registers to their defaults, both stages empty.
//  - Receiver stall: the result register holds; the input register still
//    takes one more item, then tready drops until the result is taken.
module key_short_long_press_classifier_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: now_ms[31:0], port_value[39:32], read_ok[40], boot_button_low[41],
    //        sleep_active[42], resume_time_ms[74:43], touch_forced_off[75], zero[79:76]
    input  logic [kspc_pkg::S_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: action[0]
    input  logic                              i_s_axis_tuser,
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: fired_action[1:0], machine_state[3:2], sampling_on[4], zero[7:5]
    output logic [kspc_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    // config write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kspc_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [kspc_pkg::CFG_W-1:0]        i_cfg_data
);

    kspc_pkg::t_cfg    cfg;
    kspc_pkg::t_item   r_item;
    kspc_pkg::t_result result;
    kspc_pkg::t_result r_out;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              advance;
    logic              s_take;

    assign o_cfg_ready = 1'b1;

    kspc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // item moves to the result register when that is empty or being drained
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload register, unpacked from the stream
    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_item.action           <= i_s_axis_tuser;
            r_item.now_ms           <= i_s_axis_tdata[31:0];
            r_item.port_value       <= i_s_axis_tdata[39:32];
            r_item.read_ok          <= i_s_axis_tdata[40];
            r_item.boot_button_low  <= i_s_axis_tdata[41];
            r_item.sleep_active     <= i_s_axis_tdata[42];
            r_item.resume_time_ms   <= i_s_axis_tdata[74:43];
            r_item.touch_forced_off <= i_s_axis_tdata[75];
        end
    end

    kspc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.sampling_on, r_out.machine_state,
                              r_out.fired_action};

endmodule

@@ hw/rtl/kspc_checker.sv @@
// Port-level checks for the press classifier, bound to the top level.
// Depends on kspc_pkg for phase and action codes.
module kspc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_tvalid,
    input logic                          i_m_axis_tready,
    input logic [kspc_pkg::M_DATA_W-1:0] i_out_tdata
);

    // results are empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_tvalid)
        else $error("result valid after reset");

    // sampling request follows the phase
    a_sampling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid |-> (i_out_tdata[4] == (i_out_tdata[3:2] != kspc_pkg::PH_REST)))
        else $error("sampling flag disagrees with phase");

    // a long press leaves the key pressed; a short press ends in rest
    a_fire_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && (i_out_tdata[1:0] != kspc_pkg::FIRE_NONE) |->
        ((i_out_tdata[1:0] == kspc_pkg::FIRE_BACKLIGHT) ==
         (i_out_tdata[3:2] == kspc_pkg::PH_PRESS)) &&
        (i_out_tdata[3:2] != kspc_pkg::PH_PEND))
        else $error("fired action inconsistent with phase");

    // unused phase code and padding never appear
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid |-> (i_out_tdata[3:2] != 2'd3) && (i_out_tdata[7:5] == 3'd0))
        else $error("bad phase code or padding");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_tvalid && !i_m_axis_tready |=> i_out_tvalid && $stable(i_out_tdata))
        else $error("stalled result changed");

endmodule

bind key_short_long_press_classifier_top kspc_checker u_kspc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_tvalid    (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_out_tdata     (o_m_axis_tdata)
);

@@ dv/key_short_long_press_classifier_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for key_short_long_press_classifier_top: directed and random
// press sequences over the stream ports, results checked by an in-bench predictor.
// Depends on kspc_pkg and the classifier RTL.

// Scoreboard: keeps its own copy of the registers and the press machine,
// predicts one result per accepted item and checks results in order.
class key_press_scoreboard;
    logic [kspc_pkg::CFG_W-1:0]  debounce_time;
    logic [kspc_pkg::CFG_W-1:0]  short_hold_min;
    logic [kspc_pkg::CFG_W-1:0]  long_hold_min;
    logic [kspc_pkg::CFG_W-1:0]  cooldown_ms;
    logic [kspc_pkg::CFG_W-1:0]  resume_block_ms;
    logic [kspc_pkg::PORT_W-1:0] key_mask;

    logic [1:0]  press_phase;
    logic [31:0] edge_ms;
    logic [31:0] press_ms;
    logic [31:0] last_fire_ms;
    bit          long_fired;

    kspc_pkg::t_result expected_results[$];
    int errors;

    function new();
        debounce_time      = kspc_pkg::RST_DEBOUNCE;
        short_hold_min     = kspc_pkg::RST_SHORT_MIN;
        long_hold_min      = kspc_pkg::RST_LONG_MIN;
        cooldown_ms        = kspc_pkg::RST_COOLDOWN;
        resume_block_ms    = kspc_pkg::RST_RESUME;
        key_mask           = kspc_pkg::RST_KEY_MASK;
        press_phase        = kspc_pkg::PH_REST;
        edge_ms            = '0;
        press_ms           = '0;
        last_fire_ms       = '0;
        long_fired         = 1'b0;
        errors             = 0;
    endfunction

    function void set_reg(logic [kspc_pkg::IDX_W-1:0] idx, logic [kspc_pkg::CFG_W-1:0] val);
        case (idx)
            kspc_pkg::REG_DEBOUNCE:  debounce_time      = val;
            kspc_pkg::REG_SHORT_MIN: short_hold_min     = val;
            kspc_pkg::REG_LONG_MIN:  long_hold_min      = val;
            kspc_pkg::REG_COOLDOWN:  cooldown_ms        = val;
            kspc_pkg::REG_RESUME:    resume_block_ms    = val;
            kspc_pkg::REG_KEY_MASK:  key_mask           = val[kspc_pkg::PORT_W-1:0];
            default: ;
        endcase
    endfunction

    // all time differences wrap modulo 2^32
    function void note_item(kspc_pkg::t_item it);
        kspc_pkg::t_result res;
        logic [31:0] since_resume;
        logic [31:0] since_edge;
        logic [31:0] since_fire;
        logic [31:0] held;
        bit blocked;
        bit down;
        bit cool;
        since_resume = it.now_ms - it.resume_time_ms;
        since_edge   = it.now_ms - edge_ms;
        since_fire   = it.now_ms - last_fire_ms;
        held         = it.now_ms - press_ms;
        blocked = (it.resume_time_ms != '0) && (since_resume < {16'b0, resume_block_ms});
        down    = it.read_ok && ((it.port_value & key_mask) == '0);
        cool    = since_fire >= {16'b0, cooldown_ms};
        res.fired_action = kspc_pkg::FIRE_NONE;
        if (it.action == kspc_pkg::ACT_EDGE) begin
            if (!it.sleep_active && !blocked && press_phase == kspc_pkg::PH_REST) begin
                press_phase = kspc_pkg::PH_PEND;
                edge_ms     = it.now_ms;
            end
        end else if (blocked || it.sleep_active || it.boot_button_low) begin
            press_phase = kspc_pkg::PH_REST;
            long_fired  = 1'b0;
        end else if (press_phase == kspc_pkg::PH_PEND) begin
            if (since_edge >= {16'b0, debounce_time}) begin
                if (down) begin
                    press_phase = kspc_pkg::PH_PRESS;
                    press_ms    = it.now_ms;
                end else begin
                    press_phase = kspc_pkg::PH_REST;
                    long_fired  = 1'b0;
                end
            end
        end else if (press_phase == kspc_pkg::PH_PRESS) begin
            if (down) begin
                if (!long_fired && held >= {16'b0, long_hold_min} && cool) begin
                    res.fired_action = kspc_pkg::FIRE_BACKLIGHT;
                    long_fired       = 1'b1;
                    last_fire_ms     = it.now_ms;
                end
            end else begin
                if (!long_fired && held >= {16'b0, short_hold_min} && cool) begin
                    res.fired_action = it.touch_forced_off ? kspc_pkg::FIRE_WAKE
                                                           : kspc_pkg::FIRE_TOUCH;
                    last_fire_ms     = it.now_ms;
                end
                press_phase = kspc_pkg::PH_REST;
                long_fired  = 1'b0;
            end
        end else begin
            press_phase = kspc_pkg::PH_REST;
        end
        res.machine_state = press_phase;
        res.sampling_on   = (press_phase != kspc_pkg::PH_REST);
        expected_results.push_back(res);
    endfunction

    task report_mismatch(string what);
        errors++;
        if (errors <= 40)
            $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(kspc_pkg::t_result got);
        kspc_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result %0h with nothing outstanding", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.fired_action !== want.fired_action)
            report_mismatch($sformatf("fired_action %0d, predicted %0d",
                                      got.fired_action, want.fired_action));
        if (got.machine_state !== want.machine_state)
            report_mismatch($sformatf("machine_state %0d, predicted %0d",
                                      got.machine_state, want.machine_state));
        if (got.sampling_on !== want.sampling_on)
            report_mismatch($sformatf("sampling_on %0d, predicted %0d",
                                      got.sampling_on, want.sampling_on));
    endtask
endclass

module key_short_long_press_classifier_top_test;
    import kspc_pkg::*;

    // idling patterns, one per phase of the run
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    // indexes past the register file: writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE  = 115;
    localparam int RECV_HOLD_CYCLES = 80;

    logic                i_clk;
    logic                i_rst_n         = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;
    logic                i_s_axis_tuser  = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b1;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index     = '0;
    logic [CFG_W-1:0]    i_cfg_data      = '0;

    key_short_long_press_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    key_press_scoreboard sb;
    t_idle       idle_mode  = IDLE_NONE;
    int          recv_hold  = 0;     // cycles the receiver still has to hold off
    int          items_sent = 0;
    logic [31:0] wall_ms;            // running millisecond clock of the random part
    t_result     got_result;

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // percentage of cycles in which a side idles under a given pattern
    function automatic int idle_pct(t_idle m, bit recv_side);
        case (m)
            IDLE_SEND: return recv_side ? 0 : 75;
            IDLE_RECV: return recv_side ? 75 : 0;
            IDLE_BOTH: return 20;
            default:   return 0;
        endcase
    endfunction

    // Receiver: tready moves on the falling edge. A requested hold-off is
    // counted down here, independent of what the sender is doing.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            i_m_axis_tready = 1'b0;
            recv_hold       = recv_hold - 1;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= idle_pct(idle_mode, 1'b1));
        end
    end

    // Result monitor: a transaction is taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_result.fired_action  = o_m_axis_tdata[1:0];
            got_result.machine_state = o_m_axis_tdata[3:2];
            got_result.sampling_on   = o_m_axis_tdata[4];
            sb.check_result(got_result);
        end
    end

    // Offer one item, after a random gap, and hold it until the slave takes it.
    // valid stays high across back-to-back transactions.
    task automatic push_item(input t_item it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct(idle_mode, 1'b0))
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = it.action;
        i_s_axis_tdata  = {4'b0, it.touch_forced_off, it.resume_time_ms, it.sleep_active,
                           it.boot_button_low, it.read_ok, it.port_value, it.now_ms};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result, plus the pipe depth
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] short_min,
                             input logic [CFG_W-1:0] long_min, input logic [CFG_W-1:0] cool,
                             input logic [CFG_W-1:0] resume, input logic [CFG_W-1:0] mask);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_SHORT_MIN, short_min);
        write_reg(REG_LONG_MIN, long_min);
        write_reg(REG_COOLDOWN, cool);
        write_reg(REG_RESUME, resume);
        write_reg(REG_KEY_MASK, mask);
    endtask

    function automatic t_item dir_item(logic act, logic [31:0] t, logic [7:0] port, logic rd,
                                       logic boot, logic sleep, logic [31:0] resume,
                                       logic forced);
        t_item it;
        it.action           = act;
        it.now_ms           = t;
        it.port_value       = port;
        it.read_ok          = rd;
        it.boot_button_low  = boot;
        it.sleep_active     = sleep;
        it.resume_time_ms   = resume;
        it.touch_forced_off = forced;
        return it;
    endfunction

    // Item with random content around a wanted key level. Now and then a
    // guard fires (resume window, sleep, boot button, failed read).
    function automatic t_item make_item(logic act, logic [31:0] t, bit down);
        t_item      it;
        logic [7:0] mask;
        mask = sb.key_mask;
        it = '0;
        it.action           = act;
        it.now_ms           = t;
        it.port_value       = 8'($urandom);
        it.read_ok          = 1'b1;
        it.touch_forced_off = 1'($urandom);
        if (down) begin
            it.port_value = it.port_value & ~mask;
        end else if ((it.port_value & mask) == '0) begin
            // a zero mask reads as pressed, so only a failed read lets go
            if (mask == '0 || $urandom_range(0, 3) == 0)
                it.read_ok = 1'b0;
            else
                it.port_value = it.port_value | mask;
        end
        case ($urandom_range(0, 39))
            0: it.resume_time_ms  = t - $urandom_range(0, sb.resume_block_ms + 40);
            1: it.resume_time_ms  = $urandom;
            2: it.sleep_active    = 1'b1;
            3: it.boot_button_low = 1'b1;
            4: it.read_ok         = 1'b0;
            default: ;
        endcase
        return it;
    endfunction

    // One well-formed press: edge, debounce, ticks while held, release.
    // Hold time lands short of, between or past the two thresholds.
    task automatic press_run();
        logic [31:0] press_at;
        logic [31:0] hold;
        logic [31:0] rel_at;
        int n;
        wall_ms = wall_ms + $urandom_range(0, 2 * sb.cooldown_ms + 60);
        push_item(make_item(ACT_EDGE, wall_ms, 1'b1));
        if ($urandom_range(0, 3) == 0)
            push_item(make_item(ACT_TICK, wall_ms + $urandom_range(0, sb.debounce_time), 1'b1));
        press_at = wall_ms + sb.debounce_time + $urandom_range(0, 2);
        push_item(make_item(ACT_TICK, press_at, 1'b1));
        case ($urandom_range(0, 2))
            0:       hold = $urandom_range(0, sb.short_hold_min + 2);
            1:       hold = $urandom_range(sb.short_hold_min, sb.long_hold_min);
            default: hold = sb.long_hold_min + $urandom_range(0, 100);
        endcase
        n = $urandom_range(0, 6);
        for (int k = 1; k <= n; k++)
            push_item(make_item(ACT_TICK, press_at + hold * k / (n + 1), 1'b1));
        if ($urandom_range(0, 1))
            push_item(make_item(ACT_TICK, press_at + hold, 1'b1));
        rel_at = press_at + hold + $urandom_range(0, 1);
        push_item(make_item(ACT_TICK, rel_at, 1'b0));
        wall_ms = rel_at;
    endtask

    // Fully random item, times anywhere in the 32-bit range
    task automatic noise_item();
        t_item it;
        it.action           = 1'($urandom);
        it.now_ms           = $urandom_range(0, 1) ? $urandom : wall_ms + $urandom_range(0, 500);
        it.port_value       = 8'($urandom);
        it.read_ok          = 1'($urandom);
        it.boot_button_low  = 1'($urandom);
        it.sleep_active     = 1'($urandom);
        it.resume_time_ms   = $urandom_range(0, 1) ? $urandom : 32'd0;
        it.touch_forced_off = 1'($urandom);
        push_item(it);
    endtask

    // Random phase. With pressure on, the receiver holds off for a long
    // stretch while items keep coming, and later the sender waits for the
    // pipe to empty before going on.
    task automatic random_phase(input t_idle mode, input bit pressure);
        int start;
        bit held_off;
        bit paused;
        start    = items_sent;
        held_off = 1'b0;
        paused   = 1'b0;
        idle_mode = mode;
        while (items_sent - start < ITEMS_PER_PHASE) begin
            if (pressure && !held_off && items_sent - start >= 40) begin
                recv_hold = RECV_HOLD_CYCLES;
                held_off  = 1'b1;
            end
            if (pressure && !paused && items_sent - start >= 80) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
                press_run();
            else
                noise_item();
        end
    endtask

    // Main sequence
    initial begin
        sb = new();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part on the reset register values (key on bit 2).
        // Short press at exactly the minimum hold gives a touch toggle.
        push_item(dir_item(ACT_EDGE, 32'd1000, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1010, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1025, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1054, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1055, 8'h04, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        // long press fires once at the threshold, release then gives nothing
        push_item(dir_item(ACT_EDGE, 32'd1100, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1125, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1574, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1575, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1700, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd1800, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        // short press while touch is forced off: wake
        push_item(dir_item(ACT_EDGE, 32'd2000, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1));
        push_item(dir_item(ACT_TICK, 32'd2025, 8'h00, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1));
        push_item(dir_item(ACT_TICK, 32'd2100, 8'h04, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1));
        // short press inside the cooldown: nothing fires
        push_item(dir_item(ACT_EDGE, 32'd2110, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd2135, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd2200, 8'h04, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        // edges ignored in sleep, in the resume window and when not at rest
        push_item(dir_item(ACT_EDGE, 32'd3000, 8'hFB, 1'b1, 1'b0, 1'b1, 32'd0, 1'b0));
        push_item(dir_item(ACT_EDGE, 32'd3000, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd2950, 1'b0));
        push_item(dir_item(ACT_EDGE, 32'd3200, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_EDGE, 32'd3201, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        // failed read after debounce counts as released
        push_item(dir_item(ACT_TICK, 32'd3230, 8'hFB, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        // boot button while pressed sends the machine to rest; tick at rest
        push_item(dir_item(ACT_EDGE, 32'd3300, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd3325, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd3330, 8'hFB, 1'b1, 1'b1, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'd3340, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        // debounce and hold across the 32-bit wrap of the time
        push_item(dir_item(ACT_EDGE, 32'hFFFF_FFF0, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'h0000_0009, 8'hFB, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        push_item(dir_item(ACT_TICK, 32'h0000_0030, 8'h04, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));

        wall_ms = $urandom;

        // all registers at zero: key mask zero reads as always pressed
        drain();
        write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        random_phase(IDLE_SEND, 1'b0);

        // all registers at full scale; upper mask bits must be dropped
        drain();
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(IDLE_RECV, 1'b0);

        // small random timings, back-to-back traffic with a long receiver stall
        drain();
        write_all(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 60)),
                  CFG_W'($urandom_range(60, 400)), CFG_W'($urandom_range(0, 300)),
                  CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(1, 255)));
        random_phase(IDLE_NONE, 1'b1);

        // writes past the register file, then defaults back
        drain();
        write_reg(REG_SPARE_6, CFG_W'($urandom));
        write_reg(REG_SPARE_7, CFG_W'($urandom));
        write_all(RST_DEBOUNCE, RST_SHORT_MIN, RST_LONG_MIN, RST_COOLDOWN, RST_RESUME,
                  {8'h00, RST_KEY_MASK});
        random_phase(IDLE_BOTH, 1'b0);

        drain();
        write_all(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 60)),
                  CFG_W'($urandom_range(60, 400)), CFG_W'($urandom_range(0, 300)),
                  CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 255)));
        random_phase(IDLE_BOTH, 1'b1);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/kspc_pkg.sv
hw/rtl/kspc_cfg.sv
hw/rtl/kspc_core.sv
hw/rtl/key_short_long_press_classifier_top.sv
hw/rtl/kspc_checker.sv
dv/key_short_long_press_classifier_top_test.sv
